FILE: design/length_prefixed_frame_parser_top_defines.svh
// Assertion macros for the length-prefixed frame parser.
// Included by the top level; expects clk and rst_n in scope.
`ifndef LENGTH_PREFIXED_FRAME_PARSER_TOP_DEFINES_SVH
`define LENGTH_PREFIXED_FRAME_PARSER_TOP_DEFINES_SVH

// Condition must hold in the same cycle as the trigger
`define LFP_ASSERT_NOW(label, trig, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (cond)) \
        else $error(msg);

// Condition must hold in the cycle after the trigger
`define LFP_ASSERT_NEXT(label, trig, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) \
        else $error(msg);

`endif

FILE: design/lfp_pkg.sv
// Shared types and constants for the length-prefixed frame parser.
// No dependencies.
package lfp_pkg;

    // Parser phases
    typedef enum logic [2:0] {
        PH_START   = 3'd0,
        PH_LEN     = 3'd1,
        PH_FINISH  = 3'd2,
        PH_PAYLOAD = 3'd3,
        PH_FOOTER  = 3'd4
    } phase_t;

    // Result kinds
    typedef enum logic [2:0] {
        K_PAYLOAD = 3'd0,
        K_GOOD    = 3'd1,
        K_BADHDR  = 3'd2,
        K_NONPOS  = 3'd3,
        K_BADFTR  = 3'd4,
        K_TIMEOUT = 3'd5
    } kind_t;

    // Configuration register indexes
    typedef enum logic [1:0] {
        CFG_START_BYTE  = 2'd0,
        CFG_FINISH_BYTE = 2'd1,
        CFG_FOOTER_BYTE = 2'd2,
        CFG_TIMEOUT     = 2'd3
    } cfg_idx_t;

    localparam int CFG_DATA_W  = 32;
    localparam int QUEUE_DEPTH = 2;
    localparam int IDX_W       = 4;

    // Classified item handed from front to back
    typedef struct packed {
        logic       is_tick;
        logic [7:0] rx_byte;
        logic       start_hit;
        logic       finish_hit;
        logic       footer_hit;
    } item_t;

    // Back-end status seen by the top level
    typedef struct packed {
        phase_t phase;
        logic   fire;
        logic   terminal;
    } back_status_t;

endpackage

FILE: design/lfp_if.sv
// Valid/ready channel interfaces for input items and result items.
// No dependencies.
interface lfp_in_if;
    logic       valid;
    logic       ready;
    logic       cmd;
    logic [7:0] rx_byte;

    modport source (output valid, output cmd, output rx_byte, input ready);
    modport sink   (input valid, input cmd, input rx_byte, output ready);
endinterface

interface lfp_out_if;
    logic       valid;
    logic       ready;
    logic [2:0] kind;
    logic [7:0] payload_byte;
    logic       last_payload;

    modport source (output valid, output kind, output payload_byte, output last_payload,
                    input ready);
    modport sink   (input valid, input kind, input payload_byte, input last_payload,
                    output ready);
endinterface

FILE: design/lfp_front.sv
// Front end: takes input transfers and classifies each byte against the
// configured sync and footer values. Depends on lfp_pkg and lfp_in_if.
module lfp_front
    import lfp_pkg::*;
(
    lfp_in_if.sink     in_ch,
    input  logic [7:0] start_byte,
    input  logic [7:0] finish_byte,
    input  logic [7:0] trailer_byte,
    input  logic       q_ready,
    output logic       push,
    output item_t      push_item
);

    // Accept whenever the queue has room
    assign in_ch.ready = q_ready;
    assign push        = in_ch.valid && q_ready;

    // Classification
    always_comb
    begin
        push_item.is_tick    = in_ch.cmd;
        push_item.rx_byte    = in_ch.rx_byte;
        push_item.start_hit  = (in_ch.rx_byte == start_byte);
        push_item.finish_hit = (in_ch.rx_byte == finish_byte);
        push_item.footer_hit = (in_ch.rx_byte == trailer_byte);
    end

endmodule

FILE: design/lfp_queue.sv
// Short FIFO of classified items between front and back.
// Depends on lfp_pkg.
module lfp_queue
    import lfp_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  push,
    input  item_t push_item,
    output logic  push_ready,
    output logic  q_valid,
    output item_t q_item,
    input  logic  pop,
    output logic [$clog2(QUEUE_DEPTH+1)-1:0] q_count
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH+1);

    item_t             mem [QUEUE_DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              do_push, do_pop;

    assign push_ready = (count_reg != CNT_W'(QUEUE_DEPTH));
    assign q_valid    = (count_reg != '0);
    assign q_item     = mem[rd_ptr_reg];
    assign q_count    = count_reg;
    assign do_push    = push && push_ready;
    assign do_pop     = pop && q_valid;

    // Pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH-1)) ? '0
                                                               : wr_ptr_reg + PTR_W'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH-1)) ? '0
                                                               : rd_ptr_reg + PTR_W'(1);
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= push_item;
        end
    end

endmodule

FILE: design/lfp_back.sv
// Back end: the deframing state machine, idle timer and result register.
// Depends on lfp_pkg and lfp_out_if.
module lfp_back
    import lfp_pkg::*;
#(
    parameter int SYNC_LEN   = 4,
    parameter int FOOTER_LEN = 4,
    parameter int LEN_BYTES  = 8
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         q_valid,
    input  item_t        q_item,
    output logic         q_pop,
    input  logic [31:0]  timeout_ticks,
    lfp_out_if.source    out_ch,
    output back_status_t status
);

    localparam int LEN_W = 8 * LEN_BYTES;

    phase_t           phase_reg, phase_next;
    logic [IDX_W-1:0] idx_reg, idx_next, idx_inc;
    logic             hdr_good_reg, hdr_good_next;
    logic [LEN_W-1:0] len_reg, len_next, len_shift;
    logic [LEN_W-1:0] left_reg, left_next;
    logic             ftr_good_reg, ftr_good_next;
    logic [31:0]      idle_reg, idle_next;
    logic             out_valid_reg, out_valid_next;
    kind_t            out_kind_reg;
    logic [7:0]       out_byte_reg;
    logic             out_last_reg;

    logic             fire, do_restart, hdr_ok, ftr_ok, is_last;
    kind_t            res_kind;
    logic [7:0]       res_byte;
    logic             res_last;

    assign idx_inc = idx_reg + IDX_W'(1);
    assign q_pop   = q_valid && (!out_valid_reg || out_ch.ready);

    // Length bytes arrive low first: shift in from the top
    generate
        if (LEN_BYTES == 1)
        begin : g_len_one
            assign len_shift = q_item.rx_byte;
        end
        else
        begin : g_len_many
            assign len_shift = {q_item.rx_byte, len_reg[LEN_W-1:8]};
        end
    endgenerate

    // Next state and result
    always_comb
    begin
        phase_next    = phase_reg;
        idx_next      = idx_reg;
        hdr_good_next = hdr_good_reg;
        len_next      = len_reg;
        left_next     = left_reg;
        ftr_good_next = ftr_good_reg;
        idle_next     = idle_reg;
        fire          = 1'b0;
        do_restart    = 1'b0;
        res_kind      = K_PAYLOAD;
        res_byte      = '0;
        res_last      = 1'b0;
        hdr_ok        = hdr_good_reg && q_item.finish_hit;
        ftr_ok        = ftr_good_reg && q_item.footer_hit;
        is_last       = (left_reg[LEN_W-1:1] == '0);

        if (q_pop)
        begin
            if (q_item.is_tick)
            begin
                // Idle timer tick
                if (timeout_ticks != '0)
                begin
                    if (idle_reg >= timeout_ticks)
                    begin
                        do_restart = 1'b1;
                        fire       = 1'b1;
                        res_kind   = K_TIMEOUT;
                    end
                    else
                    begin
                        idle_next = idle_reg + 32'd1;
                    end
                end
            end
            else
            begin
                idle_next = '0;
                case (phase_reg)
                    PH_START:
                    begin
                        if (!q_item.start_hit)
                        begin
                            hdr_good_next = 1'b0;
                        end
                        idx_next = idx_inc;
                        if (idx_inc >= IDX_W'(SYNC_LEN))
                        begin
                            phase_next = PH_LEN;
                            idx_next   = '0;
                        end
                    end
                    PH_LEN:
                    begin
                        len_next = len_shift;
                        idx_next = idx_inc;
                        if (idx_inc >= IDX_W'(LEN_BYTES))
                        begin
                            phase_next = PH_FINISH;
                            idx_next   = '0;
                        end
                    end
                    PH_FINISH:
                    begin
                        hdr_good_next = hdr_ok;
                        idx_next      = idx_inc;
                        if (idx_inc >= IDX_W'(SYNC_LEN))
                        begin
                            if (!hdr_ok)
                            begin
                                do_restart = 1'b1;
                                fire       = 1'b1;
                                res_kind   = K_BADHDR;
                            end
                            else if (len_reg[LEN_W-1] || (len_reg == '0))
                            begin
                                do_restart = 1'b1;
                                fire       = 1'b1;
                                res_kind   = K_NONPOS;
                            end
                            else
                            begin
                                left_next  = len_reg;
                                phase_next = PH_PAYLOAD;
                                idx_next   = '0;
                            end
                        end
                    end
                    PH_PAYLOAD:
                    begin
                        if (left_reg != '0)
                        begin
                            left_next = left_reg - LEN_W'(1);
                        end
                        if (is_last)
                        begin
                            phase_next    = PH_FOOTER;
                            idx_next      = '0;
                            ftr_good_next = 1'b1;
                        end
                        fire     = 1'b1;
                        res_kind = K_PAYLOAD;
                        res_byte = q_item.rx_byte;
                        res_last = is_last;
                    end
                    PH_FOOTER:
                    begin
                        ftr_good_next = ftr_ok;
                        idx_next      = idx_inc;
                        if (idx_inc >= IDX_W'(FOOTER_LEN))
                        begin
                            do_restart = 1'b1;
                            fire       = 1'b1;
                            res_kind   = ftr_ok ? K_GOOD : K_BADFTR;
                        end
                    end
                    default:
                    begin
                        do_restart = 1'b1;
                    end
                endcase
            end

            // Back to start of header after any frame-level result
            if (do_restart)
            begin
                phase_next    = PH_START;
                idx_next      = '0;
                hdr_good_next = 1'b1;
                len_next      = '0;
                left_next     = '0;
                ftr_good_next = 1'b1;
                idle_next     = '0;
            end
        end

        // Result register: loads on a result, empties on a transfer
        if (fire)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ch.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_START;
            idx_reg       <= '0;
            hdr_good_reg  <= 1'b1;
            len_reg       <= '0;
            left_reg      <= '0;
            ftr_good_reg  <= 1'b1;
            idle_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            idx_reg       <= idx_next;
            hdr_good_reg  <= hdr_good_next;
            len_reg       <= len_next;
            left_reg      <= left_next;
            ftr_good_reg  <= ftr_good_next;
            idle_reg      <= idle_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            out_kind_reg <= res_kind;
            out_byte_reg <= res_byte;
            out_last_reg <= res_last;
        end
    end

    assign out_ch.valid        = out_valid_reg;
    assign out_ch.kind         = out_kind_reg;
    assign out_ch.payload_byte = out_byte_reg;
    assign out_ch.last_payload = out_last_reg;

    assign status.phase    = phase_reg;
    assign status.fire     = fire;
    assign status.terminal = fire && (res_kind != K_PAYLOAD);

endmodule

FILE: design/length_prefixed_frame_parser_top.sv
// Path: an input transfer is written into the queue, the back end pops it from there,
// and any result it produces is loaded into the result register that drives out_ch.
// Throughput: one item per cycle while the result register is empty or being read;
// a two-entry queue decouples the input from result stalls.
// Reset: rst_n (asynchronous, active low) clears configuration to zero, empties
// the queue and the result register, and puts the parser at the start of a header.
`include "length_prefixed_frame_parser_top_defines.svh"

module length_prefixed_frame_parser_top
    import lfp_pkg::*;
#(
    parameter int SYNC_LEN   = 4,
    parameter int FOOTER_LEN = 4,
    parameter int LEN_BYTES  = 8
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    lfp_in_if.sink                in_ch,
    lfp_out_if.source             out_ch,
    input  logic                  cfg_we,
    input  logic [1:0]            cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata
);

    localparam int CNT_W = $clog2(QUEUE_DEPTH+1);

    logic [7:0]       start_byte_reg;
    logic [7:0]       finish_byte_reg;
    logic [7:0]       trailer_byte_reg;
    logic [31:0]      timeout_reg;

    logic             push, push_ready, q_valid, q_pop;
    item_t            push_item, q_item;
    logic [CNT_W-1:0] q_count;
    back_status_t     status;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_byte_reg   <= '0;
            finish_byte_reg  <= '0;
            trailer_byte_reg <= '0;
            timeout_reg      <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_idx_t'(cfg_index))
                CFG_START_BYTE:  start_byte_reg   <= cfg_wdata[7:0];
                CFG_FINISH_BYTE: finish_byte_reg  <= cfg_wdata[7:0];
                CFG_FOOTER_BYTE: trailer_byte_reg <= cfg_wdata[7:0];
                CFG_TIMEOUT:     timeout_reg      <= cfg_wdata[31:0];
                default:         ;
            endcase
        end
    end

    lfp_front u_front (
        .in_ch        (in_ch),
        .start_byte   (start_byte_reg),
        .finish_byte  (finish_byte_reg),
        .trailer_byte (trailer_byte_reg),
        .q_ready      (push_ready),
        .push         (push),
        .push_item    (push_item)
    );

    lfp_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_item  (push_item),
        .push_ready (push_ready),
        .q_valid    (q_valid),
        .q_item     (q_item),
        .pop        (q_pop),
        .q_count    (q_count)
    );

    lfp_back #(
        .SYNC_LEN   (SYNC_LEN),
        .FOOTER_LEN (FOOTER_LEN),
        .LEN_BYTES  (LEN_BYTES)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_valid       (q_valid),
        .q_item        (q_item),
        .q_pop         (q_pop),
        .timeout_ticks (timeout_reg),
        .out_ch        (out_ch),
        .status        (status)
    );

    // Checks
    `LFP_ASSERT_NEXT(a_restart, status.terminal, status.phase == PH_START, "missed restart")
    `LFP_ASSERT_NOW(a_last, out_ch.valid && out_ch.last_payload, out_ch.kind == K_PAYLOAD, "stray last")
    `LFP_ASSERT_NOW(a_q_bound, 1'b1, q_count <= CNT_W'(QUEUE_DEPTH), "queue overfilled")
    `LFP_ASSERT_NOW(a_fire_slot, status.fire, !out_ch.valid || out_ch.ready, "result overwrite")

endmodule

FILE: sim/tb_length_prefixed_frame_parser_top.sv
// Self-checking testbench for length_prefixed_frame_parser_top: bytes and ticks are streamed in,
// results are predicted by a behavioural deframer and compared field by field.
// Depends on lfp_pkg, lfp_in_if and lfp_out_if from the design.
`timescale 1ns / 1ps

module tb_length_prefixed_frame_parser_top;
    import lfp_pkg::*;

    localparam int SYNC_LEN   = 4;
    localparam int FOOTER_LEN = 4;
    localparam int LEN_BYTES  = 8;
    localparam int HOLD_CYCLES = 400;

    // One link item: a received byte or a time tick
    typedef struct packed {
        logic       cmd;
        logic [7:0] rx_byte;
    } link_item_t;

    // One result item as the block reports it
    typedef struct packed {
        kind_t      kind;
        logic [7:0] pbyte;
        logic       last;
    } frame_result_t;

    // Deframer state
    typedef struct {
        phase_t      phase;
        int unsigned fidx;
        logic        hdr_ok;
        logic [63:0] len_acc;
        logic [63:0] left;
        logic        ftr_ok;
        logic [31:0] idle;
    } deframer_state_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic                  cfg_we;
    cfg_idx_t              cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wdata;

    lfp_in_if  in_ch();
    lfp_out_if out_ch();

    length_prefixed_frame_parser_top #(
        .SYNC_LEN   (SYNC_LEN),
        .FOOTER_LEN (FOOTER_LEN),
        .LEN_BYTES  (LEN_BYTES)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_ch),
        .out_ch    (out_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    // Register copies, all zero out of reset
    logic [7:0]  start_val   = 8'h00;
    logic [7:0]  finish_val  = 8'h00;
    logic [7:0]  footer_val  = 8'h00;
    logic [31:0] timeout_val = 32'h0;

    link_item_t      link_items_q[$];
    frame_result_t   expected_results_q[$];
    deframer_state_t plan_state;   // state as seen while scheduling stimulus
    deframer_state_t track_state;  // state advanced on accepted transfers
    int unsigned     mismatches = 0;
    bit              sprinkle_ticks = 1'b0;

    int unsigned hold_reqs = 0;
    int unsigned holds_served = 0;
    int unsigned hold_left = 0;
    logic [31:0] rx_cyc = 32'h0;
    int unsigned burst_left = 0;
    int unsigned gap_left = 0;
    link_item_t    next_item;
    frame_result_t seen, want, got_pred;

    // Clock, 12 ns period
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    function automatic deframer_state_t fresh_state();
        deframer_state_t s;
        s.phase   = PH_START;
        s.fidx    = 0;
        s.hdr_ok  = 1'b1;
        s.len_acc = 64'h0;
        s.left    = 64'h0;
        s.ftr_ok  = 1'b1;
        s.idle    = 32'h0;
        return s;
    endfunction

    // Advance the deframer by one item; returns 1 when a result is produced
    function automatic bit deframe_step(inout deframer_state_t s, input logic cmd,
                                        input logic [7:0] b, output frame_result_t r);
        r = '{kind: K_PAYLOAD, pbyte: 8'h00, last: 1'b0};
        if (cmd)
        begin
            if (timeout_val == 32'h0)
                return 1'b0;
            if (s.idle >= timeout_val)
            begin
                s = fresh_state();
                r.kind = K_TIMEOUT;
                return 1'b1;
            end
            s.idle = s.idle + 1;
            return 1'b0;
        end
        s.idle = 32'h0;
        case (s.phase)
            PH_START:
            begin
                if (b != start_val)
                    s.hdr_ok = 1'b0;
                s.fidx++;
                if (s.fidx >= SYNC_LEN)
                begin
                    s.phase = PH_LEN;
                    s.fidx  = 0;
                end
                return 1'b0;
            end
            PH_LEN:
            begin
                s.len_acc = s.len_acc | (64'(b) << (8 * (s.fidx % 8)));
                s.fidx++;
                if (s.fidx >= LEN_BYTES)
                begin
                    s.phase = PH_FINISH;
                    s.fidx  = 0;
                end
                return 1'b0;
            end
            PH_FINISH:
            begin
                if (b != finish_val)
                    s.hdr_ok = 1'b0;
                s.fidx++;
                if (s.fidx < SYNC_LEN)
                    return 1'b0;
                // a sync mismatch outranks the length check
                if (!s.hdr_ok)
                begin
                    s = fresh_state();
                    r.kind = K_BADHDR;
                    return 1'b1;
                end
                if (s.len_acc[8*LEN_BYTES-1] || s.len_acc == 64'h0)
                begin
                    s = fresh_state();
                    r.kind = K_NONPOS;
                    return 1'b1;
                end
                s.left  = s.len_acc;
                s.phase = PH_PAYLOAD;
                s.fidx  = 0;
                return 1'b0;
            end
            PH_PAYLOAD:
            begin
                r.pbyte = b;
                r.last  = (s.left <= 64'd1);
                if (s.left != 64'h0)
                    s.left = s.left - 64'd1;
                if (r.last)
                begin
                    s.phase  = PH_FOOTER;
                    s.fidx   = 0;
                    s.ftr_ok = 1'b1;
                end
                return 1'b1;
            end
            PH_FOOTER:
            begin
                if (b != footer_val)
                    s.ftr_ok = 1'b0;
                s.fidx++;
                if (s.fidx < FOOTER_LEN)
                    return 1'b0;
                r.kind = s.ftr_ok ? K_GOOD : K_BADFTR;
                s = fresh_state();
                return 1'b1;
            end
            default:
            begin
                s = fresh_state();
                return 1'b0;
            end
        endcase
    endfunction

    task automatic report_mismatch(input string msg);
        mismatches++;
        if (mismatches <= 10)
            $display("%s", msg);
    endtask

    // Stimulus scheduling
    task automatic send(input logic cmd, input logic [7:0] b);
        frame_result_t r;
        link_items_q.push_back('{cmd: cmd, rx_byte: b});
        void'(deframe_step(plan_state, cmd, b, r));
    endtask

    // Byte, occasionally preceded by a short run of ticks
    task automatic send_byte(input logic [7:0] b);
        if (sprinkle_ticks && $urandom_range(0, 15) == 0)
            repeat ($urandom_range(1, 3)) send(1'b1, 8'($urandom));
        send(1'b0, b);
    endtask

    function automatic logic [7:0] flip_some(input logic [7:0] b);
        return b ^ 8'($urandom_range(1, 255));
    endfunction

    // bad_pos picks a start (0..SYNC_LEN-1) or finish byte to spoil; -1 spoils none
    task automatic send_header(input logic [63:0] len, input int bad_pos);
        for (int i = 0; i < SYNC_LEN; i++)
            send_byte(i == bad_pos ? flip_some(start_val) : start_val);
        for (int i = 0; i < LEN_BYTES; i++)
            send_byte(len[8*i +: 8]);
        for (int i = 0; i < SYNC_LEN; i++)
            send_byte(i + SYNC_LEN == bad_pos ? flip_some(finish_val) : finish_val);
    endtask

    task automatic send_payload(input int n);
        repeat (n) send_byte(8'($urandom));
    endtask

    task automatic send_footer(input int bad_pos);
        for (int i = 0; i < FOOTER_LEN; i++)
            send_byte(i == bad_pos ? flip_some(footer_val) : footer_val);
    endtask

    function automatic bit short_timeout();
        return timeout_val != 32'h0 && timeout_val <= 32'd40;
    endfunction

    // Bring the scheduled stream back to the start of a header
    task automatic realign();
        int guard;
        guard = 0;
        while (!(plan_state.phase == PH_START && plan_state.fidx == 0) && guard < 400)
        begin
            guard++;
            if (plan_state.phase == PH_LEN)
                send(1'b0, 8'hFF);   // forces a negative length
            else if (plan_state.phase == PH_PAYLOAD && plan_state.left > 64'd64
                     && short_timeout())
                repeat (timeout_val + 1) send(1'b1, 8'($urandom));
            else
                send(1'b0, 8'($urandom));
        end
    endtask

    // Mostly well-formed frames, the rest spoilt frames, tick runs and noise
    task automatic schedule_random(input int n_items);
        int          goal;
        int unsigned sel;
        int          len;
        logic [63:0] bad_len;
        goal = link_items_q.size() + n_items;
        while (link_items_q.size() < goal)
        begin
            sprinkle_ticks = ($urandom_range(0, 4) == 0);
            sel = $urandom_range(0, 99);
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 48) : $urandom_range(1, 12);
            if (sel < 55)
            begin
                send_header(64'(len), -1);
                send_payload(len);
                send_footer(-1);
            end
            else if (sel < 63)
                send_header({$urandom, $urandom}, $urandom_range(0, 2*SYNC_LEN-1));
            else if (sel < 70)
            begin
                case ($urandom_range(0, 2))
                    0:       bad_len = 64'h0;
                    1:       bad_len = 64'h8000_0000_0000_0000;
                    default: bad_len = {1'b1, 31'($urandom), 32'($urandom)};
                endcase
                send_header(bad_len, -1);
            end
            else if (sel < 78)
            begin
                send_header(64'(len), -1);
                send_payload(len);
                send_footer($urandom_range(0, FOOTER_LEN-1));
            end
            else if (sel < 86)
            begin
                if (short_timeout() && $urandom_range(0, 1) == 0)
                    repeat (timeout_val + 1) send(1'b1, 8'($urandom));
                else
                    repeat ($urandom_range(1, 6)) send(1'b1, 8'($urandom));
            end
            else if (sel < 92 && short_timeout())
            begin
                // length far too long to finish: the idle timeout ends it
                send_header({1'b0, 31'($urandom), 32'($urandom)} | 64'h1_0000_0000, -1);
                send_payload($urandom_range(1, 5));
                repeat (timeout_val + 1) send(1'b1, 8'($urandom));
            end
            else
                repeat ($urandom_range(1, 8)) send(1'($urandom_range(0, 1)), 8'($urandom));
            sprinkle_ticks = 1'b0;
            realign();
        end
    endtask

    task automatic write_reg(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] val);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic set_regs(input logic [7:0] s, input logic [7:0] f, input logic [7:0] ft,
                            input logic [31:0] t);
        write_reg(CFG_START_BYTE, 32'(s));
        write_reg(CFG_FINISH_BYTE, 32'(f));
        write_reg(CFG_FOOTER_BYTE, 32'(ft));
        write_reg(CFG_TIMEOUT, t);
        start_val   = s;
        finish_val  = f;
        footer_val  = ft;
        timeout_val = t;
    endtask

    // Sender idle, every result in, then a short settling margin
    task automatic wait_drain();
        while (link_items_q.size() != 0 || in_ch.valid || expected_results_q.size() != 0)
            @(negedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Input driver: bursts of transfers separated by random gaps
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_ch.valid   <= 1'b0;
            in_ch.cmd     <= 1'b0;
            in_ch.rx_byte <= 8'h00;
            burst_left = 0;
            gap_left   = 0;
        end
        else if (!in_ch.valid || in_ch.ready)
        begin
            if (gap_left != 0)
            begin
                gap_left--;
                in_ch.valid <= 1'b0;
            end
            else if (link_items_q.size() != 0)
            begin
                next_item = link_items_q.pop_front();
                in_ch.valid   <= 1'b1;
                in_ch.cmd     <= next_item.cmd;
                in_ch.rx_byte <= next_item.rx_byte;
                if (burst_left > 1)
                    burst_left--;
                else
                begin
                    burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120)
                                                             : $urandom_range(1, 12);
                    gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                end
            end
            else
                in_ch.valid <= 1'b0;
        end
    end

    // Result receiver: rotating stall patterns plus requested long hold-offs
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_ch.ready <= 1'b0;
        else
        begin
            rx_cyc = rx_cyc + 1;
            if (hold_left == 0 && holds_served != hold_reqs)
            begin
                hold_left = HOLD_CYCLES;
                holds_served++;
            end
            if (hold_left != 0)
            begin
                hold_left--;
                out_ch.ready <= 1'b0;
            end
            else
            begin
                case (rx_cyc[9:8])
                    2'd0:    out_ch.ready <= 1'b1;
                    2'd1:    out_ch.ready <= 1'($urandom_range(0, 1));
                    2'd2:    out_ch.ready <= ($urandom_range(0, 7) != 0);
                    default: out_ch.ready <= (rx_cyc[2:0] != 3'd5) && (rx_cyc[3:0] != 4'd9);
                endcase
            end
        end
    end

    // Monitor: check result transfers, then predict from input transfers
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_ch.valid && out_ch.ready)
            begin
                seen = '{kind: kind_t'(out_ch.kind), pbyte: out_ch.payload_byte,
                         last: out_ch.last_payload};
                if (expected_results_q.size() == 0)
                    report_mismatch($sformatf("%0t: unexpected kind=%0d byte=%02h last=%0d",
                                              $time, seen.kind, seen.pbyte, seen.last));
                else
                begin
                    want = expected_results_q.pop_front();
                    if (out_ch.kind !== want.kind || out_ch.payload_byte !== want.pbyte
                        || out_ch.last_payload !== want.last)
                        report_mismatch($sformatf(
                            "%0t: exp k=%0d b=%02h l=%0d got k=%0d b=%02h l=%0d",
                            $time, want.kind, want.pbyte, want.last,
                            out_ch.kind, out_ch.payload_byte, out_ch.last_payload));
                end
            end
            if (in_ch.valid && in_ch.ready)
            begin
                if (deframe_step(track_state, in_ch.cmd, in_ch.rx_byte, got_pred))
                    expected_results_q.push_back(got_pred);
            end
        end
    end

    // Run limit
    initial
    begin
        #3000000;
        $display("length_prefixed_frame_parser_top verification failed");
        $finish;
    end

    // Sequence of phases
    initial
    begin
        cfg_we        = 1'b0;
        cfg_index     = CFG_START_BYTE;
        cfg_wdata     = '0;
        plan_state    = fresh_state();
        track_state   = fresh_state();
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // Reset values: ticks do nothing with the timeout off, minimal good frame
        send(1'b1, 8'hFF);
        send(1'b1, 8'h00);
        send_header(64'd1, -1);
        send(1'b0, 8'hFF);
        send_footer(-1);
        wait_drain();

        // Extreme sync values, shortest timeout
        set_regs(8'hFF, 8'h00, 8'hFF, 32'd1);
        send(1'b1, 8'h00);
        send(1'b1, 8'h00);                                  // abort between frames
        send_header(64'hFFFF_FFFF_FFFF_FFFF, SYNC_LEN);     // bad sync beats bad length
        send_header(64'h0, -1);
        send_header(64'h8000_0000_0000_0000, -1);
        send_header(64'd2, -1);
        send(1'b0, 8'h00);
        send(1'b1, 8'hA5);                                  // a byte clears the idle count
        send(1'b0, 8'hFF);
        send(1'b1, 8'h5A);
        send_footer(-1);
        send_header(64'd1, -1);
        send(1'b0, 8'h5A);
        send_footer(FOOTER_LEN - 1);
        send_header(64'h7FFF_FFFF_FFFF_FFFF, -1);
        send(1'b0, 8'h33);
        send(1'b1, 8'h00);
        send(1'b1, 8'h00);                                  // abort inside payload
        wait_drain();

        // Random phases over several register settings
        set_regs(8'hA5, 8'h5A, 8'hC3, 32'hFFFF_FFFF);
        schedule_random(200);
        wait_drain();

        set_regs(8'($urandom), 8'($urandom), 8'($urandom), $urandom_range(2, 20));
        schedule_random(200);
        hold_reqs++;
        wait_drain();

        set_regs(8'h00, 8'hFF, 8'h00, 32'h0);
        schedule_random(200);
        hold_reqs++;
        wait_drain();

        set_regs(8'($urandom), 8'($urandom), 8'($urandom), 32'd1);
        schedule_random(200);
        wait_drain();

        repeat (8) @(posedge clk);
        if (mismatches == 0)
            $display("length_prefixed_frame_parser_top verification clean");
        else
            $display("length_prefixed_frame_parser_top verification failed");
        $finish;
    end

endmodule

FILE: length_prefixed_frame_parser_top.f
+incdir+design
design/lfp_pkg.sv
design/lfp_if.sv
design/lfp_front.sv
design/lfp_queue.sv
design/lfp_back.sv
design/length_prefixed_frame_parser_top.sv
sim/tb_length_prefixed_frame_parser_top.sv
